### rtl/fmx_pkg.sv
// Package for the hardware mutex with a FIFO wait queue.
// Holds command and status codes, field widths, the queue interface structs and the result struct.
// No dependencies.
package fmx_pkg;

  // Task identifier width, fixed by the request and result formats.
  localparam int unsigned TaskW = 4;

  // Default depth of the wait queue.
  localparam int unsigned DefMaxWaiters = 8;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_LOCK    = 2'd0,
    CMD_TRYLOCK = 2'd1,
    CMD_UNLOCK  = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  // Control from the lock logic to the wait queue.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TaskW-1:0] push_task;
  } wq_ctrl_t;

  // Status from the wait queue to the lock logic.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [TaskW-1:0] head_task;
  } wq_stat_t;

  // One result item.
  typedef struct packed {
    logic [TaskW-1:0] owner_now;
    logic             locked_now;
    logic [TaskW-1:0] wake_task;
    logic             wake_valid;
    status_e          status;
  } result_t;

endpackage

### rtl/fifo_mutex_with_ownership_handoff_top.sv
// Hardware mutex with a FIFO wait queue and ownership handoff to the oldest waiter.
// Latency: one result per request, valid on the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; the output register refills when taken.
// The head of the wait queue is read from RAM ahead of use, so a pop never waits for it.
// Reset (rst_ni low, asynchronous) frees the mutex and empties the queue; no clearing pass.
// Depends on fmx_pkg and fmx_wait_queue.
module fifo_mutex_with_ownership_handoff_top import fmx_pkg::*; #(
  parameter int unsigned MaxWaiters = DefMaxWaiters
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] cmd, [5:2] task_id, [7:6] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [1:0] status, [2] wake_valid, [6:3] wake_task, [7] locked_now,
  // [11:8] owner_now, [15:12] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic             in_acc;
  logic [1:0]       cmd;
  logic [TaskW-1:0] tid;

  logic             held_q, held_d;
  logic [TaskW-1:0] owner_q, owner_d;
  logic             out_valid_q;
  result_t          res_q, res_d;

  wq_ctrl_t         wq_ctrl;
  wq_stat_t         wq_stat;

  // Request fields and handshake.
  assign cmd             = s_axis_tdata_i[1:0];
  assign tid             = s_axis_tdata_i[2 +: TaskW];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Lock, trylock and unlock decisions.
  always_comb begin
    held_d            = held_q;
    owner_d           = owner_q;
    wq_ctrl.push      = 1'b0;
    wq_ctrl.pop       = 1'b0;
    wq_ctrl.push_task = tid;
    res_d.status      = ST_REFUSED;
    res_d.wake_valid  = 1'b0;
    res_d.wake_task   = '0;
    case (cmd_e'(cmd))
      CMD_LOCK, CMD_TRYLOCK: begin
        if (!held_q) begin
          held_d       = 1'b1;
          owner_d      = tid;
          res_d.status = ST_OK;
        end else if ((cmd_e'(cmd) == CMD_LOCK) && !wq_stat.full) begin
          wq_ctrl.push = in_acc;
          res_d.status = ST_QUEUED;
        end
      end
      CMD_UNLOCK: begin
        if (held_q && (owner_q == tid)) begin
          if (!wq_stat.empty) begin
            wq_ctrl.pop      = in_acc;
            owner_d          = wq_stat.head_task;
            res_d.wake_valid = 1'b1;
            res_d.wake_task  = wq_stat.head_task;
          end else begin
            held_d  = 1'b0;
            owner_d = '0;
          end
          res_d.status = ST_OK;
        end
      end
      default: begin
        res_d.status = ST_REFUSED;
      end
    endcase
    res_d.locked_now = held_d;
    res_d.owner_now  = held_d ? owner_d : '0;
  end

  // Mutex state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      owner_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        held_q  <= held_d;
        owner_q <= owner_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  fmx_wait_queue #(
    .MaxWaiters (MaxWaiters)
  ) u_wait_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (wq_ctrl),
    .stat_o (wq_stat)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  // A free mutex never has waiters.
  a_free_no_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> wq_stat.empty)
    else $error("mutex free while tasks wait");

  // A handoff always reports success and leaves the woken task as owner.
  a_wake_is_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.wake_valid) |->
      (res_q.status == ST_OK) && res_q.locked_now && (res_q.owner_now == res_q.wake_task))
    else $error("handoff result inconsistent");

  // A queued lock leaves the mutex held.
  a_queued_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wq_ctrl.push) |=> held_q)
    else $error("queued request on a free mutex");

endmodule

### rtl/fmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read during write to the same address returns the old contents.
// No dependencies.
module fmx_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fmx_wait_queue.sv
// FIFO wait queue of task identifiers for the mutex.
// Keeps head and tail pointers and a fill count; entries live in fmx_ram.
// The entry at the head is read ahead so that it is ready for a pop.
// Depends on fmx_pkg and fmx_ram.
module fmx_wait_queue import fmx_pkg::*; #(
  parameter int unsigned MaxWaiters = DefMaxWaiters
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wq_ctrl_t ctrl_i,
  output wq_stat_t stat_o
);

  localparam int unsigned PtrW = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1;
  localparam int unsigned CntW = $clog2(MaxWaiters + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(MaxWaiters - 1);

  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             byp_q, byp_d;
  logic [TaskW-1:0] byp_task_q;
  logic [TaskW-1:0] ram_rdata;

  // Pointer and count updates.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastSlot) ? '0 : tail_q + PtrW'(1);
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == LastSlot) ? '0 : head_q + PtrW'(1);
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  // A write to the slot being read ahead is forwarded next cycle.
  assign byp_d = ctrl_i.push && (tail_q == head_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_task_q <= ctrl_i.push_task;
  end

  fmx_ram #(
    .Width (TaskW),
    .Depth (MaxWaiters),
    .AddrW (PtrW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (tail_q),
    .wdata_i (ctrl_i.push_task),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CntW'(MaxWaiters));
  assign stat_o.head_task = byp_q ? byp_task_q : ram_rdata;

  // A pop from an empty queue or a push into a full one is a control slip.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !stat_o.empty)
    else $error("wait queue popped while empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !stat_o.full)
    else $error("wait queue pushed while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxWaiters))
    else $error("wait queue count out of range");

endmodule

### bench/fifo_mutex_with_ownership_handoff_top_tb.sv
// Self-checking testbench for the hardware mutex with a FIFO wait queue.
// Predicts each reply from a private copy of the lock state and checks every returned word.
// Depends on fmx_pkg and fifo_mutex_with_ownership_handoff_top.
module fifo_mutex_with_ownership_handoff_top_tb;
  import fmx_pkg::*;

  localparam int unsigned MaxWaiters  = DefMaxWaiters;
  localparam logic [1:0]  CmdUndefined = 2'd3;
  localparam int          CycleLimit  = 100000;
  localparam int          SettleCycles = 10;
  localparam int          ReportLimit = 10;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE
  } drain_mode_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Private copy of the lock state.
  logic                mx_held;
  logic [TaskW-1:0]    mx_owner;
  int unsigned         mx_waiters;
  logic [TaskW-1:0]    mx_ring [MaxWaiters];
  int unsigned         mx_head;
  int unsigned         mx_tail;

  // Replies still owed by the block, oldest first.
  result_t     pending_replies[$];
  int          reply_errors;
  int          cycle_count;

  // Sender pacing and receiver stall control.
  bit          sender_pacing = 1'b1;
  int          burst_left;
  int          stall_request;
  int          hold_left;
  int          mode_left;
  drain_mode_e drain_mode;

  fifo_mutex_with_ownership_handoff_top #(
    .MaxWaiters(MaxWaiters)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Works out the reply to one request and advances the lock state.
  function automatic result_t predict_mutex_reply(input logic [1:0] op,
                                                  input logic [TaskW-1:0] tid);
    result_t r;
    r        = '0;
    r.status = ST_REFUSED;
    if (op == CMD_LOCK || op == CMD_TRYLOCK) begin
      if (!mx_held) begin
        mx_held  = 1'b1;
        mx_owner = tid;
        r.status = ST_OK;
      end else if (op == CMD_LOCK && mx_waiters < MaxWaiters) begin
        // A lock on a held mutex joins the tail of the queue, even from the owner.
        mx_ring[mx_tail] = tid;
        mx_tail          = (mx_tail + 1) % MaxWaiters;
        mx_waiters++;
        r.status = ST_QUEUED;
      end
    end else if (op == CMD_UNLOCK && mx_held && mx_owner == tid) begin
      if (mx_waiters != 0) begin
        // Ownership passes straight to the oldest waiter.
        mx_owner     = mx_ring[mx_head];
        mx_head      = (mx_head + 1) % MaxWaiters;
        mx_waiters--;
        r.wake_valid = 1'b1;
        r.wake_task  = mx_owner;
      end else begin
        mx_held  = 1'b0;
        mx_owner = '0;
      end
      r.status = ST_OK;
    end
    r.locked_now = mx_held;
    r.owner_now  = mx_held ? mx_owner : '0;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    reply_errors++;
    if (reply_errors <= ReportLimit) begin
      $display("Mismatch: %s", msg);
    end
  endfunction

  // Offers one request, honouring the burst pattern, and waits until it is taken.
  task automatic send_request(input logic [1:0] op, input logic [TaskW-1:0] tid);
    int gap;
    bit taken;
    if (sender_pacing && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, tid, op};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_replies.push_back(predict_mutex_reply(op, tid));
  endtask

  // Receiver: changes its stall pattern now and then, and obeys long hold-offs.
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        drain_mode = drain_mode_e'($urandom_range(DRAIN_FREE, DRAIN_SPARSE));
        mode_left  = $urandom_range(4, 40);
      end
      mode_left--;
      case (drain_mode)
        DRAIN_FREE: begin
          m_axis_tready_i <= 1'b1;
        end
        DRAIN_COIN: begin
          m_axis_tready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Each reply taken at the coming edge is checked against the oldest prediction.
  always @(negedge clk_i) begin : reply_checker
    result_t seen;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("reply 0x%h with no request outstanding", m_axis_tdata_o));
      end else begin
        want = pending_replies.pop_front();
        if (seen.status !== want.status || seen.wake_valid !== want.wake_valid ||
            seen.wake_task !== want.wake_task || seen.locked_now !== want.locked_now ||
            seen.owner_now !== want.owner_now) begin
          flag_error($sformatf(
            "expected st=%0d wv=%0d wt=%0d lk=%0d own=%0d, got st=%0d wv=%0d wt=%0d lk=%0d own=%0d",
            want.status, want.wake_valid, want.wake_task, want.locked_now, want.owner_now,
            seen.status, seen.wake_valid, seen.wake_task, seen.locked_now, seen.owner_now));
        end
      end
    end
  end

  // Refusals on a free mutex, trylock rules, a full queue and the handoff order.
  task automatic test_directed_cases();
    send_request(CMD_UNLOCK, 4'd0);       // unlock of a free mutex
    send_request(CmdUndefined, 4'd15);    // command with no meaning
    send_request(CMD_TRYLOCK, 4'd15);     // trylock on a free mutex grants it
    send_request(CMD_TRYLOCK, 4'd15);     // trylock by the owner is refused
    send_request(CMD_TRYLOCK, 4'd3);      // trylock by another task is refused
    send_request(CMD_LOCK, 4'd15);        // lock by the owner is queued
    send_request(CMD_LOCK, 4'd0);
    send_request(CMD_LOCK, 4'd5);
    send_request(CMD_LOCK, 4'd10);
    send_request(CMD_LOCK, 4'd1);
    send_request(CMD_LOCK, 4'd2);
    send_request(CMD_LOCK, 4'd4);
    send_request(CMD_LOCK, 4'd8);         // queue now full
    send_request(CMD_LOCK, 4'd7);         // refused while full
    send_request(CMD_UNLOCK, 4'd3);       // unlock by a task that does not own it
    send_request(CmdUndefined, 4'd0);
    // Hand the mutex down the whole queue, then free it.
    while (mx_held) begin
      send_request(CMD_UNLOCK, mx_owner);
    end
    send_request(CMD_LOCK, 4'd0);
    send_request(CMD_UNLOCK, 4'd0);
  endtask

  // Mostly well-formed lock and unlock traffic with some stray requests.
  task automatic test_random_contention(input int count, input int lock_pct);
    int               pick;
    logic [TaskW-1:0] tid;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      tid  = TaskW'($urandom_range(0, (1 << TaskW) - 1));
      if (pick < lock_pct) begin
        send_request(CMD_LOCK, tid);
      end else if (pick < lock_pct + 10) begin
        send_request(CMD_TRYLOCK, tid);
      end else if (pick < 92) begin
        send_request(CMD_UNLOCK, mx_held ? mx_owner : tid);
      end else if (pick < 97) begin
        send_request(CMD_UNLOCK, tid);
      end else begin
        send_request(CmdUndefined, tid);
      end
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming back to back.
  task automatic test_output_backpressure();
    sender_pacing = 1'b0;
    stall_request = 300;
    test_random_contention(80, 45);
    sender_pacing = 1'b1;
  endtask

  initial begin
    mx_held    = 1'b0;
    mx_owner   = '0;
    mx_waiters = 0;
    mx_head    = 0;
    mx_tail    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_contention(250, 60);
    test_output_backpressure();
    test_random_contention(250, 30);

    s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (reply_errors == 0 && pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
